>>> hw/rtl/cdd_pkg.sv
package cdd_pkg;

   localparam int Stages     = 5;
   localparam int YearOffset = 400;
   localparam int Recip100   = 5243;
   localparam int RecipShift = 19;
   localparam int DaysPerYr  = 365;
   localparam int SatMax     = 65535;
   localparam int DnW        = 21;

   typedef struct packed {
      logic [11:0] first_year;
      logic [3:0]  first_month;
      logic [4:0]  first_day;
      logic [4:0]  first_hour;
      logic [11:0] second_year;
      logic [3:0]  second_month;
      logic [4:0]  second_day;
      logic [4:0]  second_hour;
   } cdd_req_type;

   typedef struct packed {
      logic [15:0] abs_days;
      logic [15:0] abs_hours;
      logic        second_not_earlier;
   } cdd_rsp_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } cdd_en_type;

   function automatic logic [8:0] months_before(input logic [3:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/calendar_date_distance_top.sv
// Calendar date distance between two Gregorian date-hours.
// Request channel: req_valid / req_ready / req_payload carries both dates
// (year, month, day, hour each). Response channel: rsp_valid / rsp_ready /
// rsp_payload returns the absolute day distance, the absolute hour distance
// (both saturated at 65535) and a flag set when the second date-hour is not
// earlier than the first. Every request gives exactly one response, in order.
// The result passes through five register stages from request accept to
// rsp_valid (reciprocal products, quotients and year product, day number,
// differences, hours and saturation).
// Throughput: one request per cycle while rsp_ready is high.
// Stall: each stage holds while the stage after it is full and stalled;
// req_ready drops only when all five stages hold data and rsp_ready is low.
// Bubbles are squeezed out, so requests keep entering during a stall until
// the pipeline is full.
// Reset (synchronous, active high) empties the pipeline; rsp_valid is low
// after it.
module calendar_date_distance_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdd_pkg::cdd_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cdd_pkg::cdd_rsp_type  rsp_payload
);
   import cdd_pkg::*;

   logic [Stages-1:0] vld_ff, vld_in;
   logic [Stages-1:0] adv;
   cdd_en_type        en;

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || rsp_ready;
      for (int k = Stages-2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      for (int k = 0; k < Stages; k++) begin
         if (adv[k]) begin
            vld_in[k] = (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k-1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign en.s1 = adv[0];
   assign en.s2 = adv[1];
   assign en.s3 = adv[2];
   assign en.s4 = adv[3];
   assign en.s5 = adv[4];

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[Stages-1];

   // ordering flag on raw fields
   logic later;

   always_comb begin
      if (req_payload.first_year != req_payload.second_year) begin
         later = req_payload.second_year > req_payload.first_year;
      end else if (req_payload.first_month != req_payload.second_month) begin
         later = req_payload.second_month > req_payload.first_month;
      end else if (req_payload.first_day != req_payload.second_day) begin
         later = req_payload.second_day > req_payload.first_day;
      end else begin
         later = req_payload.second_hour >= req_payload.first_hour;
      end
   end

   // side band alongside the day-number stages
   logic [2:0][4:0] h1_ff, h2_ff;
   logic [2:0]      later_ff;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         h1_ff[0]    <= req_payload.first_hour;
         h2_ff[0]    <= req_payload.second_hour;
         later_ff[0] <= later;
      end
      if (en.s2) begin
         h1_ff[1]    <= h1_ff[0];
         h2_ff[1]    <= h2_ff[0];
         later_ff[1] <= later_ff[0];
      end
      if (en.s3) begin
         h1_ff[2]    <= h1_ff[1];
         h2_ff[2]    <= h2_ff[1];
         later_ff[2] <= later_ff[1];
      end
   end

   logic [DnW-1:0] dn1, dn2;

   cdd_day_num u_dn1 (
      .clock (clock),
      .en    (en),
      .year  (req_payload.first_year),
      .month (req_payload.first_month),
      .day   (req_payload.first_day),
      .dn    (dn1)
   );

   cdd_day_num u_dn2 (
      .clock (clock),
      .en    (en),
      .year  (req_payload.second_year),
      .month (req_payload.second_month),
      .day   (req_payload.second_day),
      .dn    (dn2)
   );

   cdd_diff u_diff (
      .clock (clock),
      .en    (en),
      .dn1   (dn1),
      .dn2   (dn2),
      .h1    (h1_ff[2]),
      .h2    (h2_ff[2]),
      .later (later_ff[2]),
      .rsp   (rsp_payload)
   );

endmodule

>>> hw/rtl/cdd_day_num.sv
module cdd_day_num (
   input  logic                  clock,
   input  cdd_pkg::cdd_en_type   en,
   input  logic [11:0]           year,
   input  logic [3:0]            month,
   input  logic [4:0]            day,
   output logic [cdd_pkg::DnW-1:0] dn
);
   import cdd_pkg::*;

   // stage 1: offset year, clamp month, reciprocal products for /100 and /400
   logic [12:0] y;
   logic [12:0] n;
   logic [3:0]  mc;
   logic [12:0] n_ff, n_in;
   logic [1:0]  ylo_ff, ylo_in;
   logic [24:0] pn100_ff, pn100_in, py100_ff, py100_in;
   logic [23:0] pn400_ff, pn400_in, py400_ff, py400_in;
   logic [8:0]  mb_ff, mb_in;
   logic        late_ff, late_in;
   logic [4:0]  day_ff, day_in;

   always_comb begin
      y = 13'({1'b0, year} + 13'(YearOffset));
      n = y - 13'd1;
      if (month == 4'd0) begin
         mc = 4'd1;
      end else if (month > 4'd12) begin
         mc = 4'd12;
      end else begin
         mc = month;
      end
      n_in     = n;
      ylo_in   = y[1:0];
      pn100_in = 25'(n) * 25'(Recip100);
      py100_in = 25'(y) * 25'(Recip100);
      pn400_in = 24'(n[12:2]) * 24'(Recip100);
      py400_in = 24'(y[12:2]) * 24'(Recip100);
      mb_in    = months_before(mc);
      late_in  = (mc > 4'd2);
      day_in   = day;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         n_ff     <= n_in;
         ylo_ff   <= ylo_in;
         pn100_ff <= pn100_in;
         py100_ff <= py100_in;
         pn400_ff <= pn400_in;
         py400_ff <= py400_in;
         mb_ff    <= mb_in;
         late_ff  <= late_in;
         day_ff   <= day_in;
      end
   end

   // stage 2: quotients, leap year, year product and small sum
   logic [5:0]      qn100, qy100;
   logic [4:0]      qn400, qy400;
   logic            leap;
   logic [DnW-1:0]  p365_ff, p365_in;
   logic [11:0]     sum_ff, sum_in;

   always_comb begin
      qn100   = pn100_ff[RecipShift+5:RecipShift];
      qy100   = py100_ff[RecipShift+5:RecipShift];
      qn400   = pn400_ff[RecipShift+4:RecipShift];
      qy400   = py400_ff[RecipShift+4:RecipShift];
      // quotients step at a multiple of the divisor
      leap    = ((ylo_ff == 2'd0) && (qn100 == qy100)) || (qn400 != qy400);
      p365_in = DnW'(n_ff) * DnW'(DaysPerYr);
      sum_in  = 12'(n_ff[12:2]) - 12'(qn100) + 12'(qn400) + 12'(mb_ff)
              + 12'(leap & late_ff) + 12'(day_ff);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         p365_ff <= p365_in;
         sum_ff  <= sum_in;
      end
   end

   // stage 3: linear day number
   logic [DnW-1:0] dn_ff, dn_in;

   assign dn_in = p365_ff + DnW'(sum_ff);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         dn_ff <= dn_in;
      end
   end

   assign dn = dn_ff;

endmodule

>>> hw/rtl/cdd_diff.sv
module cdd_diff (
   input  logic                    clock,
   input  cdd_pkg::cdd_en_type     en,
   input  logic [cdd_pkg::DnW-1:0] dn1,
   input  logic [cdd_pkg::DnW-1:0] dn2,
   input  logic [4:0]              h1,
   input  logic [4:0]              h2,
   input  logic                    later,
   output cdd_pkg::cdd_rsp_type    rsp
);
   import cdd_pkg::*;

   // stage 4: signed day and hour differences
   logic signed [DnW:0] days_ff, days_in;
   logic signed [5:0]   hd_ff, hd_in;
   logic                later_ff;

   assign days_in = $signed({1'b0, dn2}) - $signed({1'b0, dn1});
   assign hd_in   = $signed({1'b0, h2}) - $signed({1'b0, h1});

   always_ff @(posedge clock) begin
      if (en.s4) begin
         days_ff  <= days_in;
         hd_ff    <= hd_in;
         later_ff <= later;
      end
   end

   // stage 5: hours, magnitudes, saturation
   logic signed [26:0] hours;
   logic [26:0]        habs;
   logic [DnW:0]       dabs;
   cdd_rsp_type        rsp_ff, rsp_in;

   always_comb begin
      hours = (27'(days_ff) <<< 4) + (27'(days_ff) <<< 3) + 27'(hd_ff);
      habs  = hours[26] ? 27'(-hours) : 27'(hours);
      dabs  = days_ff[DnW] ? (DnW+1)'(-days_ff) : (DnW+1)'(days_ff);
      rsp_in.abs_days  = (|dabs[DnW:16]) ? 16'(SatMax) : dabs[15:0];
      rsp_in.abs_hours = (|habs[26:16]) ? 16'(SatMax) : habs[15:0];
      rsp_in.second_not_earlier = later_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> hw/rtl/cdd_checker.sv
module cdd_protocol_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  cdd_pkg::cdd_rsp_type  rsp_payload
);
   import cdd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_same_day: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.abs_days == 16'd0) |-> rsp_payload.abs_hours <= 16'd31)
      else $error("hour distance too large for same day");

   a_hour_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.abs_days >= 16'd2732)
         |-> rsp_payload.abs_hours == 16'(SatMax))
      else $error("hour distance not saturated");

   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled while output not stalled");

endmodule

bind calendar_date_distance_top cdd_protocol_checker u_cdd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
